[src/opfc_pkg.sv]
// opfc_pkg: shared types, constants and byte functions of the ogg page framer
// holds the page job descriptor, the crc-32 byte step and the header byte mux
// no dependencies
package opfc_pkg;

	localparam int unsigned HDR_FIXED = 27;
	localparam int unsigned LACE_MAX  = 255;
	localparam int unsigned SEG_LIMIT = 255;
	localparam int unsigned IDX_W     = 9;

	localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_TOP      = 32'h8000_0000;
	localparam logic [31:0] SERIAL_RESET = 32'h5241_5054;
	localparam logic [7:0]  OGG_VERSION  = 8'h00;
	localparam logic [7:0]  CAPTURE [4]  = '{8'h4F, 8'h67, 8'h67, 8'h53};

	// one closed page as handed from front to back
	typedef struct packed {
		logic        fail;
		logic [7:0]  hdr_type;
		logic [63:0] granule;
		logic [31:0] seq;
		logic [7:0]  nseg;
		logic [7:0]  rem;
	} page_job_t;

	// msb-first crc-32 over one byte, no reflection
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h000000};
		for (int k = 0; k < 8; k++) begin
			c = ((c & CRC_TOP) != 32'h0) ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// header or segment table byte at position idx
	function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx, input page_job_t job,
		input logic [31:0] serial, input logic [31:0] crc);
		logic [IDX_W-1:0] off;
		logic [7:0]       seg;
		logic [7:0]       b;
		off = idx;
		seg = 8'h00;
		b   = 8'h00;
		if (idx < IDX_W'(4)) begin
			b = CAPTURE[idx[1:0]];
		end else if (idx == IDX_W'(4)) begin
			b = OGG_VERSION;
		end else if (idx == IDX_W'(5)) begin
			b = job.hdr_type;
		end else if (idx < IDX_W'(14)) begin
			off = idx - IDX_W'(6);
			b = job.granule[{off[2:0], 3'b000} +: 8];
		end else if (idx < IDX_W'(18)) begin
			off = idx - IDX_W'(14);
			b = serial[{off[1:0], 3'b000} +: 8];
		end else if (idx < IDX_W'(22)) begin
			off = idx - IDX_W'(18);
			b = job.seq[{off[1:0], 3'b000} +: 8];
		end else if (idx < IDX_W'(26)) begin
			off = idx - IDX_W'(22);
			b = crc[{off[1:0], 3'b000} +: 8];
		end else if (idx == IDX_W'(26)) begin
			b = job.nseg;
		end else begin
			// full lacing entries, then the remainder entry
			seg = 8'(idx - IDX_W'(HDR_FIXED));
			b = (seg < job.nseg - 8'd1) ? 8'(LACE_MAX) : job.rem;
		end
		return b;
	endfunction

endpackage

[src/opfc_if.sv]
// opfc_in_if / opfc_out_if: valid-ready channels of the ogg page framer
// depends on nothing
interface opfc_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic        last_byte;
	logic [7:0]  page_flags;
	logic [63:0] granule_position;
	logic [31:0] page_sequence;

	modport source (output valid, payload_byte, last_byte, page_flags, granule_position,
		page_sequence, input ready);
	modport sink (input valid, payload_byte, last_byte, page_flags, granule_position,
		page_sequence, output ready);
endinterface

interface opfc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       status;
	logic       last_out;

	modport source (output valid, out_byte, status, last_out, input ready);
	modport sink (input valid, out_byte, status, last_out, output ready);
endinterface

[src/ogg_page_framer_crc_unit.sv]
// ogg_page_framer_crc_unit: top level of the ogg page header framer
// depends on opfc_pkg, opfc_if, opfc_front, opfc_fifo and opfc_back
//
// Payload bytes are taken one per cycle, while the store is free and the job
// queue has room, into a page store of PAGE_BYTES entries; the byte with
// last_byte set closes the page and carries its header type, granule position
// and sequence number. After a close the store's single read port is busy with
// the CRC: the job crosses the queue, the header and segment table pass the CRC
// unit, then the stored payload, and no payload byte is taken until that walk
// ends. If the previous page's header bytes are still leaving, the walk starts
// only after its last byte is sent. The 27 + nseg header bytes then leave
// through an output register, one per cycle while the output is ready, as the
// next page is already loading. A page too large for the store, or with more
// than 255 segments, gives one result with status set. The store needs no
// clearing after reset.
module ogg_page_framer_crc_unit #(
	parameter int unsigned PAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	opfc_in_if.sink     payload,
	opfc_out_if.source  header,
	input  logic        serial_we,
	input  logic [31:0] serial_wdata
);

	localparam int unsigned CNT_W  = $clog2(PAGE_BYTES + 1);
	localparam int unsigned ADDR_W = $clog2(PAGE_BYTES);
	localparam int unsigned JOB_W  = $bits(opfc_pkg::page_job_t) + CNT_W;

	logic [31:0]         serial_q;
	logic                push, pop, full, empty, store_free;
	opfc_pkg::page_job_t job_in, job_out;
	logic [CNT_W-1:0]    len_in, len_out;
	logic [ADDR_W-1:0]   rd_addr;
	logic [7:0]          rd_data;
	logic [JOB_W-1:0]    q_rdata;

	// stream serial number register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serial_q <= opfc_pkg::SERIAL_RESET;
		end else if (serial_we) begin
			serial_q <= serial_wdata;
		end
	end

	opfc_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.payload    (payload),
		.push       (push),
		.job        (job_in),
		.len        (len_in),
		.fifo_full  (full),
		.store_free (store_free),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	opfc_fifo #(.DATA_W(JOB_W)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({job_in, len_in}),
		.full   (full),
		.pop    (pop),
		.rdata  (q_rdata),
		.empty  (empty)
	);

	assign {job_out, len_out} = q_rdata;

	opfc_back #(.PAGE_BYTES(PAGE_BYTES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (!empty),
		.pop        (pop),
		.job        (job_out),
		.len        (len_out),
		.serial     (serial_q),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.store_free (store_free),
		.header     (header)
	);

endmodule

[src/opfc_front.sv]
// opfc_front: takes payload bytes into the page store, counts lacing segments
// and closes each page into a job; depends on opfc_pkg and opfc_in_if
module opfc_front #(
	parameter int unsigned PAGE_BYTES = 4096,
	localparam int unsigned CNT_W  = $clog2(PAGE_BYTES + 1),
	localparam int unsigned ADDR_W = $clog2(PAGE_BYTES),
	localparam int unsigned SEG_W  = $clog2(PAGE_BYTES / opfc_pkg::LACE_MAX + 2),
	localparam int unsigned SUM_W  = CNT_W + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	opfc_in_if.sink             payload,
	output logic                push,
	output opfc_pkg::page_job_t job,
	output logic [CNT_W-1:0]    len,
	input  logic                fifo_full,
	input  logic                store_free,
	input  logic [ADDR_W-1:0]   rd_addr,
	output logic [7:0]          rd_data
);

	logic [7:0]       store_q [PAGE_BYTES];
	logic [7:0]       rd_data_q;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]       rem_q, rem_d;
	logic [SEG_W-1:0] nseg_q, nseg_d;
	logic             ovf_q, ovf_d;
	logic             busy_q;
	logic             take;
	logic             store_en;
	logic [SUM_W-1:0] page_size;

	// running count, lacing remainder and segment count
	always_comb begin
		take     = payload.valid & payload.ready;
		store_en = cnt_q < CNT_W'(PAGE_BYTES);
		cnt_d    = cnt_q;
		rem_d    = rem_q;
		nseg_d   = nseg_q;
		ovf_d    = ovf_q;
		if (store_en) begin
			cnt_d = cnt_q + CNT_W'(1);
			if (rem_q == 8'(opfc_pkg::LACE_MAX - 1)) begin
				rem_d  = 8'h00;
				nseg_d = nseg_q + SEG_W'(1);
			end else begin
				rem_d = rem_q + 8'd1;
			end
		end else begin
			ovf_d = 1'b1;
		end
		page_size = SUM_W'(opfc_pkg::HDR_FIXED) + SUM_W'(nseg_d) + SUM_W'(cnt_d);
	end

	// job for the page closed by this byte
	always_comb begin
		push         = take & payload.last_byte;
		job.fail     = ovf_d || (SUM_W'(nseg_d) > SUM_W'(opfc_pkg::SEG_LIMIT)) ||
			(page_size > SUM_W'(PAGE_BYTES));
		job.hdr_type = payload.page_flags;
		job.granule  = payload.granule_position;
		job.seq      = payload.page_sequence;
		job.nseg     = 8'(nseg_d);
		job.rem      = rem_d;
		len          = cnt_d;
	end

	// the store is locked from a page close until the back has walked it
	assign payload.ready = !busy_q && !fifo_full;
	assign rd_data       = rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			rem_q  <= 8'h00;
			nseg_q <= SEG_W'(1);
			ovf_q  <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			if (take) begin
				if (payload.last_byte) begin
					cnt_q  <= '0;
					rem_q  <= 8'h00;
					nseg_q <= SEG_W'(1);
					ovf_q  <= 1'b0;
				end else begin
					cnt_q  <= cnt_d;
					rem_q  <= rem_d;
					nseg_q <= nseg_d;
					ovf_q  <= ovf_d;
				end
			end
			if (push) begin
				busy_q <= 1'b1;
			end else if (store_free) begin
				busy_q <= 1'b0;
			end
		end
	end

	// page store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (take && store_en) begin
			store_q[cnt_q[ADDR_W-1:0]] <= payload.payload_byte;
		end
		rd_data_q <= store_q[rd_addr];
	end

endmodule

[src/opfc_fifo.sv]
// opfc_fifo: two-entry job queue between front and back
// depends on nothing
module opfc_fifo #(
	parameter int unsigned DATA_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output logic              empty
);

	logic [DATA_W-1:0] slot_q [2];
	logic              wr_q, rd_q;
	logic [1:0]        cnt_q;
	logic              do_push, do_pop;

	always_comb begin
		full    = cnt_q == 2'd2;
		empty   = cnt_q == 2'd0;
		rdata   = slot_q[rd_q];
		do_push = push && !full;
		do_pop  = pop && !empty;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= wdata;
		end
	end

endmodule

[src/opfc_back.sv]
// opfc_back: runs the page crc over header, segment table and stored payload,
// then sends header or error bytes; depends on opfc_pkg and opfc_out_if
module opfc_back #(
	parameter int unsigned PAGE_BYTES = 4096,
	localparam int unsigned CNT_W  = $clog2(PAGE_BYTES + 1),
	localparam int unsigned ADDR_W = $clog2(PAGE_BYTES),
	localparam int unsigned IDX_W  = opfc_pkg::IDX_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                pop,
	input  opfc_pkg::page_job_t job,
	input  logic [CNT_W-1:0]    len,
	input  logic [31:0]         serial,
	output logic [ADDR_W-1:0]   rd_addr,
	input  logic [7:0]          rd_data,
	output logic                store_free,
	opfc_out_if.source          header
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_HDR  = 5'b00010,
		ST_PAY  = 5'b00100,
		ST_EMIT = 5'b01000,
		ST_ERR  = 5'b10000
	} state_t;

	state_t              state_q;
	opfc_pkg::page_job_t job_q;
	logic [CNT_W-1:0]    len_q;
	logic [CNT_W-1:0]    issue_q;
	logic                rvld_s1;
	logic [31:0]         crc_q;
	logic [IDX_W-1:0]    idx_q;
	logic                hv_q;
	logic [7:0]          out_byte_q;
	logic                status_q;
	logic                last_q;
	logic [IDX_W-1:0]    total;
	logic                idx_last;
	logic                slot_free;
	logic                send;
	logic                walk_done;
	logic [7:0]          crc_in_byte;
	logic [7:0]          emit_byte;

	always_comb begin
		pop         = (state_q == ST_IDLE) && job_valid;
		total       = IDX_W'(opfc_pkg::HDR_FIXED) + IDX_W'(job_q.nseg);
		idx_last    = idx_q == total - IDX_W'(1);
		slot_free   = !hv_q || header.ready;
		send        = ((state_q == ST_EMIT) || (state_q == ST_ERR)) && slot_free;
		walk_done   = (issue_q == len_q) && !rvld_s1;
		store_free  = (pop && job.fail) || ((state_q == ST_PAY) && walk_done);
		rd_addr     = issue_q[ADDR_W-1:0];
		crc_in_byte = opfc_pkg::hdr_byte(idx_q, job_q, serial, 32'h0);
		emit_byte   = opfc_pkg::hdr_byte(idx_q, job_q, serial, crc_q);
	end

	assign header.valid    = hv_q;
	assign header.out_byte = out_byte_q;
	assign header.status   = status_q;
	assign header.last_out = last_q;

	// page sequencer with output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			job_q      <= '0;
			len_q      <= '0;
			issue_q    <= '0;
			rvld_s1    <= 1'b0;
			crc_q      <= 32'h0;
			idx_q      <= '0;
			hv_q       <= 1'b0;
			out_byte_q <= 8'h00;
			status_q   <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			// output slot: refilled on a send, emptied when taken
			if (send) begin
				hv_q <= 1'b1;
			end else if (header.ready) begin
				hv_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q   <= job;
						len_q   <= len;
						crc_q   <= 32'h0;
						idx_q   <= '0;
						state_q <= job.fail ? ST_ERR : ST_HDR;
					end
				end
				ST_HDR: begin
					// header with zeroed crc field, then segment table
					crc_q <= opfc_pkg::crc_byte(crc_q, crc_in_byte);
					if (idx_last) begin
						idx_q   <= '0;
						issue_q <= '0;
						rvld_s1 <= 1'b0;
						state_q <= ST_PAY;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_PAY: begin
					// addresses are issued ahead of the registered read; its data arrives in the next cycle
					if (issue_q != len_q) begin
						issue_q <= issue_q + CNT_W'(1);
						rvld_s1 <= 1'b1;
					end else begin
						rvld_s1 <= 1'b0;
					end
					if (rvld_s1) begin
						crc_q <= opfc_pkg::crc_byte(crc_q, rd_data);
					end
					if (walk_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_byte_q <= emit_byte;
						status_q   <= 1'b0;
						last_q     <= idx_last;
						if (idx_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				ST_ERR: begin
					if (slot_free) begin
						out_byte_q <= 8'h00;
						status_q   <= 1'b1;
						last_q     <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[src/opfc_checker.sv]
// opfc_checker: port-level assertions for ogg_page_framer_crc_unit
// bound to the top level below; depends on nothing
module opfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       status,
	input logic       last_out
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status) &&
		$stable(last_out))
		else $error("stalled result changed");

	// a page error is a single zero byte that ends the page
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> last_out && (out_byte == 8'h00))
		else $error("malformed error result");

	// the store is locked right after a page close
	a_close_lock: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("payload taken during crc walk");

	// right after a page end, no error result appears without its own page end
	a_page_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_out |=> !(out_valid && status && !last_out))
		else $error("error result without page end");

endmodule

bind ogg_page_framer_crc_unit opfc_checker u_opfc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (payload.valid),
	.in_ready  (payload.ready),
	.in_last   (payload.last_byte),
	.out_valid (header.valid),
	.out_ready (header.ready),
	.out_byte  (header.out_byte),
	.status    (header.status),
	.last_out  (header.last_out)
);
